// ----- hw/rtl/tfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Threshold fan speed controller package
// Shared types, constants and the seven-segment digit table.
// ----------------------------------------------------------------------------
package tfsc_pkg;

  localparam int unsigned TempW   = 12;  // whole degrees after dropping 4 fraction bits
  localparam int unsigned LimitW  = 7;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned PhaseW  = 5;
  localparam int unsigned GearW   = 2;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned SegW    = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_PWM_OFF = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PWM_ON  = 1'b1;

  localparam logic [SlotW-1:0] PWM_OFF_RESET = 4'd3;
  localparam logic [SlotW-1:0] PWM_ON_RESET  = 4'd6;

  localparam logic [LimitW-1:0] HIGH_RESET = 7'd30;
  localparam logic [LimitW-1:0] LOW_RESET  = 7'd20;
  localparam logic [LimitW-1:0] HIGH_MAX   = 7'd100;
  localparam logic [LimitW-1:0] HIGH_MIN   = 7'd10;
  localparam logic [LimitW-1:0] LOW_MAX    = 7'd95;
  localparam logic [LimitW-1:0] SHOW_MAX   = 7'd99;
  localparam logic [LimitW:0]   LIMIT_STEP = 8'd5;

  localparam logic [GearW-1:0] GEAR_OFF  = 2'd0;
  localparam logic [GearW-1:0] GEAR_PWM  = 2'd1;
  localparam logic [GearW-1:0] GEAR_FULL = 2'd2;

  localparam logic [ModeW-1:0] MENU_RUN  = 2'd0;
  localparam logic [ModeW-1:0] MENU_HIGH = 2'd1;
  localparam logic [ModeW-1:0] MENU_LOW  = 2'd2;

  localparam logic [SegW-1:0] SEG_DASH = 8'h40;
  localparam logic [SegW-1:0] SEG_H    = 8'h76;
  localparam logic [SegW-1:0] SEG_L    = 8'h38;

  typedef enum logic [2:0] {
    MODE_RUN  = 3'b001,
    MODE_HIGH = 3'b010,
    MODE_LOW  = 3'b100
  } mode_e;

  typedef struct packed {
    logic [TempW-1:0] temp;
    logic             set_k;
    logic             up_k;
    logic             down_k;
  } tfsc_item_t;

  typedef struct packed {
    mode_e             mode;
    logic [LimitW-1:0] high_limit;
    logic [LimitW-1:0] low_limit;
    logic [GearW-1:0]  gear;
    logic              motor;
  } tfsc_status_t;

  function automatic logic [SegW-1:0] seg_digit(input logic [3:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ----- hw/rtl/tfsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Fan controller state
// Menu keys, limit adjustment and the run-mode gear and PWM decision.
// ----------------------------------------------------------------------------
module tfsc_ctrl import tfsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  tfsc_item_t            item_i,
  input  logic [SlotW-1:0]      pwm_off_i,
  input  logic [SlotW-1:0]      pwm_on_i,
  output tfsc_status_t          status_o
);

  mode_e             mode_q, mode_d;
  logic [LimitW-1:0] high_q, high_d;
  logic [LimitW-1:0] low_q, low_d;
  logic [GearW-1:0]  gear_q, gear_d;
  logic              motor_q, motor_d;
  logic [PhaseW-1:0] phase_q, phase_d;

  logic [LimitW:0]   high_sum, low_sum;
  logic [LimitW-1:0] high_up, high_dn, low_up, low_dn;
  logic [PhaseW-1:0] period;
  logic [PhaseW:0]   phase_next;
  logic              temp_gt_high, temp_ge_low;

  // Up is applied before down, as the keys are handled in that order.
  assign high_sum = {1'b0, high_q} + LIMIT_STEP;
  assign high_up  = !item_i.up_k ? high_q :
                    (high_sum >= {1'b0, HIGH_MAX}) ? HIGH_MAX : high_sum[LimitW-1:0];
  assign high_dn  = !item_i.down_k ? high_up :
                    (high_up <= HIGH_MIN + 7'd1) ? HIGH_MIN : high_up - 7'd1;

  assign low_sum = {1'b0, low_q} + LIMIT_STEP;
  assign low_up  = !item_i.up_k ? low_q :
                   (low_sum >= {1'b0, LOW_MAX}) ? LOW_MAX : low_sum[LimitW-1:0];
  assign low_dn  = (item_i.down_k && low_up != '0) ? low_up - 7'd1 : low_up;

  assign period       = {1'b0, pwm_off_i} + {1'b0, pwm_on_i};
  assign phase_next   = {1'b0, phase_q} + 6'd1;
  assign temp_gt_high = item_i.temp > {{(TempW-LimitW){1'b0}}, high_d};
  assign temp_ge_low  = item_i.temp >= {{(TempW-LimitW){1'b0}}, low_d};

  always_comb begin
    mode_d  = mode_q;
    high_d  = high_q;
    low_d   = low_q;
    gear_d  = gear_q;
    motor_d = motor_q;
    phase_d = phase_q;

    case (mode_q)
      MODE_HIGH: begin
        high_d = high_dn;
        if (item_i.set_k) mode_d = MODE_LOW;
      end
      MODE_LOW: begin
        low_d = low_dn;
        if (item_i.set_k) mode_d = MODE_RUN;
      end
      default: begin
        mode_d = item_i.set_k ? MODE_HIGH : MODE_RUN;
      end
    endcase

    // Motor, gear and phase only move while the menu is back in run mode.
    if (mode_d == MODE_RUN) begin
      if (temp_gt_high) begin
        gear_d  = GEAR_FULL;
        motor_d = 1'b1;
        phase_d = '0;
      end else if (temp_ge_low) begin
        gear_d  = GEAR_PWM;
        motor_d = phase_q >= {1'b0, pwm_off_i};
        phase_d = (phase_next >= {1'b0, period}) ? '0 : phase_next[PhaseW-1:0];
      end else begin
        gear_d  = GEAR_OFF;
        motor_d = 1'b0;
        phase_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RUN;
      high_q  <= HIGH_RESET;
      low_q   <= LOW_RESET;
      gear_q  <= GEAR_OFF;
      motor_q <= 1'b0;
      phase_q <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      high_q  <= high_d;
      low_q   <= low_d;
      gear_q  <= gear_d;
      motor_q <= motor_d;
      phase_q <= phase_d;
    end
  end

  assign status_o.mode       = mode_d;
  assign status_o.high_limit = high_d;
  assign status_o.low_limit  = low_d;
  assign status_o.gear       = gear_d;
  assign status_o.motor      = motor_d;

endmodule

// ----- hw/rtl/tfsc_display.sv -----
// ----------------------------------------------------------------------------
// Fan controller display encoder
// Menu code and the four seven-segment digits for the updated state.
// ----------------------------------------------------------------------------
module tfsc_display import tfsc_pkg::*; (
  input  tfsc_status_t      status_i,
  input  logic [TempW-1:0]  temp_i,
  output logic [ModeW-1:0]  menu_mode_o,
  output logic [SegW-1:0]   seg_first_o,
  output logic [SegW-1:0]   seg_second_o,
  output logic [SegW-1:0]   seg_third_o,
  output logic [SegW-1:0]   seg_fourth_o
);

  logic [LimitW-1:0] shown;
  logic [14:0]       tens_prod;
  logic [3:0]        tens;
  logic [LimitW-1:0] tens_x10;
  logic [LimitW-1:0] ones;

  always_comb begin
    case (status_i.mode)
      MODE_HIGH: begin
        menu_mode_o = MENU_HIGH;
        seg_first_o = SEG_H;
        shown       = (status_i.high_limit > SHOW_MAX) ? SHOW_MAX : status_i.high_limit;
      end
      MODE_LOW: begin
        menu_mode_o = MENU_LOW;
        seg_first_o = SEG_L;
        shown       = (status_i.low_limit > SHOW_MAX) ? SHOW_MAX : status_i.low_limit;
      end
      default: begin
        menu_mode_o = MENU_RUN;
        seg_first_o = seg_digit({2'b00, status_i.gear});
        shown       = (temp_i > {{(TempW-LimitW){1'b0}}, SHOW_MAX}) ?
                      SHOW_MAX : temp_i[LimitW-1:0];
      end
    endcase
  end

  // Divide by ten as a multiply by 205/2048, exact for values below 100.
  assign tens_prod = {8'b0, shown} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign ones      = shown - tens_x10;

  assign seg_second_o = SEG_DASH;
  assign seg_third_o  = seg_digit(tens);
  assign seg_fourth_o = seg_digit(ones[3:0]);

endmodule

// ----- hw/rtl/threshold_fan_speed_controller_unit.sv -----
// ----------------------------------------------------------------------------
// Threshold fan speed controller
// Stream wrapper with input and result registers around the fan control state.
// ----------------------------------------------------------------------------
// Each input beat is one controller tick: a raw sensor word and three key
// events. The block takes one beat per clock cycle for as long as the result
// side keeps up, and every beat yields exactly one result beat. The input
// register and the result register bracket a single pass of key handling,
// limit update, gear and PWM decision and the display encoding; the
// controller state is written in the same cycle that a result is loaded,
// so back-to-back ticks see each other's updates. A stalled result does
// not stop the input side until both registers are full. The PWM slot
// registers are written on the configuration port and should only change
// while no beat is in flight.
// ----------------------------------------------------------------------------
module threshold_fan_speed_controller_unit import tfsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: [15:0] raw_temperature, [16] set_pressed, [17] up_pressed,
  //        [18] down_pressed, [23:19] zero
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  // tdata: [0] motor_on, [2:1] gear, [4:3] menu_mode, [12:5] seg_first,
  //        [20:13] seg_second, [28:21] seg_third, [36:29] seg_fourth,
  //        [39:37] zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [SlotW-1:0]     cfg_wdata_i
);

  logic              in_valid_q, in_valid_d;
  tfsc_item_t        item_q;
  logic              out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic              advance;
  logic              in_beat;

  logic [SlotW-1:0]  pwm_off_q, pwm_on_q;

  tfsc_status_t      ctrl_status;
  logic [ModeW-1:0]  menu_mode;
  logic [SegW-1:0]   seg_first, seg_second, seg_third, seg_fourth;

  // The held item moves on whenever the result register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_beat ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The sensor word carries four fraction bits; only whole degrees are kept.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      item_q.temp   <= s_axis_tdata[15:4];
      item_q.set_k  <= s_axis_tdata[16];
      item_q.up_k   <= s_axis_tdata[17];
      item_q.down_k <= s_axis_tdata[18];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_off_q <= PWM_OFF_RESET;
      pwm_on_q  <= PWM_ON_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PWM_OFF: pwm_off_q <= cfg_wdata_i;
        CFG_PWM_ON:  pwm_on_q  <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  tfsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .pwm_off_i (pwm_off_q),
    .pwm_on_i  (pwm_on_q),
    .status_o  (ctrl_status)
  );

  tfsc_display u_display (
    .status_i     (ctrl_status),
    .temp_i       (item_q.temp),
    .menu_mode_o  (menu_mode),
    .seg_first_o  (seg_first),
    .seg_second_o (seg_second),
    .seg_third_o  (seg_third),
    .seg_fourth_o (seg_fourth)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {3'b000, seg_fourth, seg_third, seg_second, seg_first,
                     menu_mode, ctrl_status.gear, ctrl_status.motor};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // Full speed always drives the motor, and gear zero never does.
  a_gear_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[2:1] != GEAR_FULL || m_axis_tdata[0]) &&
                       (m_axis_tdata[2:1] != GEAR_OFF || !m_axis_tdata[0])))
    else $error("gear and motor level disagree");

  // Limits stay inside their adjustable ranges.
  a_limit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_status.high_limit >= HIGH_MIN) && (ctrl_status.high_limit <= HIGH_MAX) &&
    (ctrl_status.low_limit <= LOW_MAX))
    else $error("limit outside its range");

  // An item moved into the pipeline shows up as a result in the next cycle.
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("result lost after advance");

  // An accepted beat is held in the input register in the next cycle.
  a_accept_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_valid_q)
    else $error("accepted beat not captured");
`endif

endmodule

// ----- tb/threshold_fan_speed_controller_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Threshold fan speed controller testbench
// Drives controller ticks on the input stream and checks every result beat
// against a cycle-free model of the menu, limit, gear and PWM behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module threshold_fan_speed_controller_unit_tb import tfsc_pkg::*;;

  // A long hold on the result side, and the number of cycles without any
  // beat on either side after which the run is declared hung.
  localparam int HOLD_CYCLES = 64;
  localparam int QUIET_LIMIT = 4000;

  // One expected result beat, split into its fields.
  typedef struct packed {
    logic             motor;
    logic [GearW-1:0] gear;
    logic [ModeW-1:0] menu;
    logic [SegW-1:0]  seg_first;
    logic [SegW-1:0]  seg_second;
    logic [SegW-1:0]  seg_third;
    logic [SegW-1:0]  seg_fourth;
  } fan_view_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = CFG_PWM_OFF;
  logic [SlotW-1:0]    cfg_wdata_i   = '0;

  // Controller state as the testbench sees it. It follows every accepted
  // tick, so the expected display for each beat is known on acceptance.
  logic [ModeW-1:0] menu_st  = MENU_RUN;
  logic [GearW-1:0] gear_st  = GEAR_OFF;
  logic             motor_st = 1'b0;
  int               high_lim = HIGH_RESET;
  int               low_lim  = LOW_RESET;
  int               phase    = 0;
  int               off_slots = PWM_OFF_RESET;
  int               on_slots  = PWM_ON_RESET;

  fan_view_t fan_view_q[$];

  int ticks_sent    = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  threshold_fan_speed_controller_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Seven-segment pattern of one decimal digit.
  function automatic logic [SegW-1:0] digit_segments(input int digit);
    case (digit)
      0:       return 8'h3F;
      1:       return 8'h06;
      2:       return 8'h5B;
      3:       return 8'h4F;
      4:       return 8'h66;
      5:       return 8'h6D;
      6:       return 8'h7D;
      7:       return 8'h07;
      8:       return 8'h7F;
      default: return 8'h6F;
    endcase
  endfunction

  // Applies one tick to the tracked state and queues the display it yields.
  // Keys are handled first (up before down, then set), and the gear decision
  // is only made when the menu ends the tick in run mode.
  task automatic step_fan_controller(input logic [15:0] raw, input logic set_k,
                                     input logic up_k, input logic down_k);
    int        deg;
    int        shown;
    int        next_phase;
    fan_view_t view;
    deg = raw >> 4;
    case (menu_st)
      MENU_HIGH: begin
        if (up_k) begin
          high_lim = high_lim + LIMIT_STEP;
          if (high_lim >= HIGH_MAX) high_lim = HIGH_MAX;
        end
        if (down_k) begin
          high_lim = high_lim - 1;
          if (high_lim <= HIGH_MIN) high_lim = HIGH_MIN;
        end
        if (set_k) menu_st = MENU_LOW;
      end
      MENU_LOW: begin
        if (up_k) begin
          low_lim = low_lim + LIMIT_STEP;
          if (low_lim >= LOW_MAX) low_lim = LOW_MAX;
        end
        if (down_k && low_lim > 0) low_lim = low_lim - 1;
        if (set_k) menu_st = MENU_RUN;
      end
      default: begin
        menu_st = set_k ? MENU_HIGH : MENU_RUN;
      end
    endcase

    if (menu_st == MENU_RUN) begin
      // The high test comes first, so crossed limits favor full speed.
      if (deg > high_lim) begin
        gear_st  = GEAR_FULL;
        motor_st = 1'b1;
        phase    = 0;
      end else if (deg >= low_lim) begin
        next_phase = phase + 1;
        gear_st    = GEAR_PWM;
        motor_st   = (phase >= off_slots);
        phase      = (next_phase >= off_slots + on_slots) ? 0 : (next_phase & 31);
      end else begin
        gear_st  = GEAR_OFF;
        motor_st = 1'b0;
        phase    = 0;
      end
    end

    if (menu_st == MENU_HIGH) begin
      view.seg_first = SEG_H;
      shown          = high_lim;
    end else if (menu_st == MENU_LOW) begin
      view.seg_first = SEG_L;
      shown          = low_lim;
    end else begin
      view.seg_first = digit_segments(gear_st);
      shown          = deg;
    end
    if (shown > SHOW_MAX) shown = SHOW_MAX;

    view.motor      = motor_st;
    view.gear       = gear_st;
    view.menu       = menu_st;
    view.seg_second = SEG_DASH;
    view.seg_third  = digit_segments(shown / 10);
    view.seg_fourth = digit_segments(shown % 10);
    fan_view_q.push_back(view);
  endtask

  task automatic flag_mismatch(input string what, input logic [OutDataW-1:0] got,
                               input logic [OutDataW-1:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one tick on the input stream, with a random gap in front of it,
  // and records its expected result once the beat is taken.
  task automatic send_tick(input logic [15:0] raw, input logic set_k,
                           input logic up_k, input logic down_k);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {5'd0, down_k, up_k, set_k, raw};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    step_fan_controller(raw, set_k, up_k, down_k);
    ticks_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Stops offering ticks until every queued result has come out, then lets
  // the two pipeline registers settle.
  task automatic wait_for_results();
    s_axis_tvalid = 1'b0;
    while (fan_view_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // The slot registers only change while no tick is in flight.
  task automatic write_pwm_slots(input logic [SlotW-1:0] off_val,
                                 input logic [SlotW-1:0] on_val);
    wait_for_results();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_PWM_OFF;
    cfg_wdata_i = off_val;
    off_slots   = off_val;
    @(negedge clk_i);
    cfg_idx_i   = CFG_PWM_ON;
    cfg_wdata_i = on_val;
    on_slots    = on_val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Sensor word that mostly lands near a limit or a display extreme, with
  // a random fraction, and now and then anywhere in the 16-bit range.
  function automatic logic [15:0] pick_raw();
    int deg;
    if ($urandom_range(99) < 15) return 16'($urandom);
    case ($urandom_range(3))
      0:       deg = low_lim;
      1:       deg = high_lim;
      2:       deg = 0;
      default: deg = SHOW_MAX;
    endcase
    deg = deg + int'($urandom_range(6)) - 3;
    if (deg < 0) deg = 0;
    return {deg[11:0], 4'($urandom)};
  endfunction

  // Key ticks inside a menu, with a per-call bias toward up or down so that
  // the limits drift into their floors and ceilings. A rare stray set press
  // breaks the sequence on purpose.
  task automatic key_ticks(input int count);
    int up_pct;
    int down_pct;
    up_pct   = $urandom_range(100);
    down_pct = $urandom_range(100);
    repeat (count) begin
      send_tick(pick_raw(), $urandom_range(99) < 3, $urandom_range(99) < up_pct,
                $urandom_range(99) < down_pct);
    end
  endtask

  task automatic run_burst(input int count);
    repeat (count) begin
      send_tick(pick_raw(), $urandom_range(99) < 4, 1'($urandom), 1'($urandom));
    end
  endtask

  // Display right after reset: each gear, the limit boundaries, a dropped
  // fraction and saturation of the shown temperature.
  task automatic test_run_display();
    send_tick(16'h0000, 1'b0, 1'b0, 1'b0);
    send_tick(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_tick(16'd20 << 4, 1'b0, 1'b0, 1'b0);
    send_tick((16'd30 << 4) | 16'hF, 1'b0, 1'b0, 1'b0);
    send_tick(16'd31 << 4, 1'b0, 1'b0, 1'b0);
    send_tick((16'd19 << 4) | 16'hF, 1'b0, 1'b0, 1'b0);
    repeat (5) send_tick(16'd25 << 4, 1'b0, 1'b0, 1'b0);
  endtask

  // Menu walk: keys are ignored in run mode, up goes before down, and set
  // is applied after the limit update of the same tick.
  task automatic test_menu_keys();
    send_tick(16'd25 << 4, 1'b0, 1'b1, 1'b1);
    send_tick(16'd25 << 4, 1'b1, 1'b1, 1'b1);
    send_tick(16'd90 << 4, 1'b0, 1'b1, 1'b0);
    send_tick(16'd90 << 4, 1'b0, 1'b0, 1'b1);
    send_tick(16'd90 << 4, 1'b0, 1'b1, 1'b1);
    send_tick(16'd90 << 4, 1'b1, 1'b1, 1'b0);
    send_tick(16'd5 << 4, 1'b0, 1'b0, 1'b1);
    send_tick(16'd5 << 4, 1'b0, 1'b1, 1'b1);
    send_tick(16'd5 << 4, 1'b1, 1'b0, 1'b1);
    send_tick(16'd30 << 4, 1'b0, 1'b0, 1'b0);
  endtask

  // Gear one PWM under several slot settings, the zero period and the
  // register extremes among them. The phase is left over from the previous
  // setting on purpose, so a shrinking period is seen too.
  task automatic test_pwm_slots();
    logic [SlotW-1:0] offs [6] = '{4'd0, 4'd15, 4'd0, 4'd15, 4'd1, 4'd7};
    logic [SlotW-1:0] ons  [6] = '{4'd1, 4'd15, 4'd0, 4'd1, 4'd15, 4'd0};
    logic [15:0]      mid_raw;
    for (int i = 0; i < 6; i++) begin
      write_pwm_slots(offs[i], ons[i]);
      mid_raw = 16'((low_lim + high_lim) / 2) << 4;
      repeat (offs[i] + ons[i] + 3) send_tick(mid_raw, 1'b0, 1'b0, 1'b0);
    end
    write_pwm_slots(PWM_OFF_RESET, PWM_ON_RESET);
  endtask

  // Drives both limits into their floors and ceilings, runs with crossed
  // limits, and shows a high limit of 100 saturated on the display.
  task automatic test_limit_extremes();
    send_tick(16'd40 << 4, 1'b1, 1'b0, 1'b0);
    repeat (40) send_tick(16'd40 << 4, 1'b0, 1'b0, 1'b1);
    send_tick(16'd40 << 4, 1'b1, 1'b0, 1'b0);
    repeat (24) send_tick(16'd40 << 4, 1'b0, 1'b0, 1'b1);
    repeat (20) send_tick(16'd40 << 4, 1'b0, 1'b1, 1'b0);
    send_tick(16'd5 << 4, 1'b1, 1'b0, 1'b0);
    // Low is now above high: hot gives full speed, otherwise off.
    send_tick(16'd50 << 4, 1'b0, 1'b0, 1'b0);
    send_tick(16'd96 << 4, 1'b0, 1'b0, 1'b0);
    send_tick(16'd10 << 4, 1'b0, 1'b0, 1'b0);
    send_tick(16'd60 << 4, 1'b1, 1'b0, 1'b0);
    repeat (19) send_tick(16'd60 << 4, 1'b0, 1'b1, 1'b0);
    send_tick(16'd60 << 4, 1'b1, 1'b0, 1'b0);
    send_tick(16'd97 << 4, 1'b1, 1'b0, 1'b0);
  endtask

  // Mostly full menu sessions with random content, mixed with run bursts,
  // after a fresh random slot setting.
  task automatic test_random_ticks(input int count);
    int start;
    write_pwm_slots(4'($urandom), 4'($urandom));
    start = ticks_sent;
    while (ticks_sent - start < count) begin
      if ($urandom_range(99) < 60) begin
        send_tick(pick_raw(), 1'b1, 1'($urandom), 1'($urandom));
        key_ticks($urandom_range(24));
        send_tick(pick_raw(), 1'b1, 1'($urandom), 1'($urandom));
        key_ticks($urandom_range(24));
        send_tick(pick_raw(), 1'b1, 1'($urandom), 1'($urandom));
      end else begin
        run_burst($urandom_range(1, 20));
      end
    end
  endtask

  // The result side holds off for a long stretch while ticks keep coming,
  // so both registers fill and the input stalls; then the sender waits for
  // every result before going on.
  task automatic test_backpressure();
    holds_asked++;
    run_burst(24);
    wait_for_results();
  endtask

  // Result side readiness. A requested hold is counted down here, one cycle
  // per falling edge; otherwise readiness follows the current idle rate.
  always @(negedge clk_i) begin
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result beat is compared field by field with the oldest pending
  // expectation.
  always @(posedge clk_i) begin : check_results
    fan_view_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fan_view_q.size() == 0) begin
        flag_mismatch("result beat with nothing pending", m_axis_tdata, '0);
      end else begin
        want = fan_view_q.pop_front();
        if (m_axis_tdata[0] !== want.motor)
          flag_mismatch("motor_on", m_axis_tdata[0], want.motor);
        if (m_axis_tdata[2:1] !== want.gear)
          flag_mismatch("gear", m_axis_tdata[2:1], want.gear);
        if (m_axis_tdata[4:3] !== want.menu)
          flag_mismatch("menu_mode", m_axis_tdata[4:3], want.menu);
        if (m_axis_tdata[12:5] !== want.seg_first)
          flag_mismatch("seg_first", m_axis_tdata[12:5], want.seg_first);
        if (m_axis_tdata[20:13] !== want.seg_second)
          flag_mismatch("seg_second", m_axis_tdata[20:13], want.seg_second);
        if (m_axis_tdata[28:21] !== want.seg_third)
          flag_mismatch("seg_third", m_axis_tdata[28:21], want.seg_third);
        if (m_axis_tdata[36:29] !== want.seg_fourth)
          flag_mismatch("seg_fourth", m_axis_tdata[36:29], want.seg_fourth);
      end
    end
  end

  // Hang detection: cycles in a row with no beat on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[%0t] no beat for %0d cycles", $time, QUIET_LIMIT);
    $display("threshold_fan_speed_controller_unit verification failed");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // First the sender idles lightly and the receiver heavily.
    send_idle_pct = 24;
    recv_idle_pct = 56;
    test_run_display();
    test_menu_keys();
    test_pwm_slots();
    test_limit_extremes();
    test_random_ticks(310);
    test_backpressure();

    // Then the other way round.
    send_idle_pct = 56;
    recv_idle_pct = 24;
    test_random_ticks(310);

    // And finally both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_ticks(310);
    test_backpressure();

    wait_for_results();
    if (mismatches == 0) begin
      $display("threshold_fan_speed_controller_unit verification clean");
    end else begin
      $display("threshold_fan_speed_controller_unit verification failed");
    end
    $finish;
  end

endmodule
